@@ hw/rtl/whole_word_literal_search_top_assert.svh @@
// assertion macros for the whole-word literal search block
`ifndef WHOLE_WORD_LITERAL_SEARCH_TOP_ASSERT_SVH
`define WHOLE_WORD_LITERAL_SEARCH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WWLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define WWLS_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);
`else
`define WWLS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define WWLS_ASSERT_AFTER_RESET(label, clk, rst, cons, msg)
`endif
`endif

@@ hw/rtl/wwls_pkg.sv @@
// shared types, constants and helper functions of the whole-word literal search block
package wwls_pkg;

   localparam int unsigned PATTERN_BYTES       = 16;
   localparam int unsigned PAT_IDX_BITS        = 4;
   localparam int unsigned LEN_BITS            = 5;
   localparam int unsigned MAX_PATTERN_DEFAULT = 16;
   localparam int unsigned POS_BITS_DEFAULT    = 32;
   localparam int unsigned OUT_POS_BITS        = 32;
   localparam int unsigned TOTAL_BITS          = 32;
   localparam int unsigned QUEUE_DEPTH         = 4;
   localparam int unsigned CSR_INDEX_BITS      = 3;
   localparam int unsigned CSR_DATA_BITS       = 64;

   // result slots of one text byte, in delivery order
   localparam int unsigned SLOT_COUNT   = 3;
   localparam int unsigned SLOT_PENDING = 0;
   localparam int unsigned SLOT_FRESH   = 1;
   localparam int unsigned SLOT_SUMMARY = 2;

   localparam logic [7:0] CHAR_NUL       = 8'd0;
   localparam logic [7:0] CHAR_SPACE     = 8'd32;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_CR        = 8'd13;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5a;
   localparam logic [7:0] CASE_DISTANCE  = 8'd32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW     = 3'd0,
      CSR_PATTERN_HIGH    = 3'd1,
      CSR_PATTERN_LENGTH  = 3'd2,
      CSR_CASE_SENSITIVE  = 3'd3,
      CSR_WHOLE_WORD      = 3'd4,
      CSR_DELIM_LOW       = 3'd5,
      CSR_DELIM_HIGH      = 3'd6,
      CSR_BEGIN_POSITION  = 3'd7
   } csr_index_type;

   typedef enum logic {
      KIND_MATCH   = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      REL_BEFORE = 2'd0,
      REL_EQUAL  = 2'd1,
      REL_AFTER  = 2'd2
   } rel_type;

   typedef struct packed {
      logic [63:0]         pattern_low;
      logic [63:0]         pattern_high;
      logic [LEN_BITS-1:0] pattern_length;
      logic                case_sensitive;
      logic                whole_word;
      logic [63:0]         delim_low;
      logic [63:0]         delim_high;
      logic [31:0]         begin_position;
   } cfg_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type                kind;
      logic [OUT_POS_BITS-1:0] match_start;
      logic [OUT_POS_BITS-1:0] match_end;
      rel_type                 begin_relation;
      logic [TOTAL_BITS-1:0]   match_total;
      logic                    position_overflow;
      logic                    last;
   } rsp_type;

   // everything the back end needs to deliver the results of one text byte
   typedef struct packed {
      logic [SLOT_COUNT-1:0]   slots;
      logic                    overflow;
      logic [OUT_POS_BITS-1:0] pend_start;
      logic [OUT_POS_BITS-1:0] pend_end;
      rel_type                 pend_rel;
      logic [TOTAL_BITS-1:0]   pend_total;
      logic [OUT_POS_BITS-1:0] fresh_start;
      logic [OUT_POS_BITS-1:0] end_pos;
      rel_type                 fresh_rel;
      logic [TOTAL_BITS-1:0]   final_total;
   } record_type;

   function automatic logic is_delim(input logic [7:0]  c,
                                     input logic [63:0] dlow,
                                     input logic [63:0] dhigh);
      logic ws;
      ws = (c == CHAR_NUL) || (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      return ws || ((c[7:6] == 2'b00) && dlow[c[5:0]]) || ((c[7:6] == 2'b01) && dhigh[c[5:0]]);
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ? c + CASE_DISTANCE : c;
   endfunction

   function automatic logic [TOTAL_BITS-1:0] sat_inc(input logic [TOTAL_BITS-1:0] v);
      return (v == '1) ? v : v + TOTAL_BITS'(1);
   endfunction

endpackage

@@ hw/rtl/wwls_stream_if.sv @@
// valid/ready stream channel carrying one payload word per handshake
interface wwls_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/whole_word_literal_search_top.sv @@
// top level of the whole-word literal search block
//
// req_channel takes one text byte per word, with end_of_text on the last byte
// of a text. rsp_channel returns 0 to 3 words per byte: a match held back for
// its right neighbour, a match ending at this byte, then the end of text
// summary; last marks the final word of a byte. Registers are written through
// csr_write_enable/csr_index/csr_write_data between texts.
// Throughput: one byte per cycle while each byte yields at most one word and
// the receiver takes every word; the output register delivers one word per
// cycle while the receiver is ready, so a byte with two or three words holds
// the back end for each of its words in turn.
// A result word passes from the queue entry written as its byte is taken,
// through the record register, to the output register.
// A four-entry record queue parts the matcher from the output side: when the
// receiver stalls, bytes keep flowing until the queue fills, then req ready
// drops. Bytes that give no result never take a queue entry.
// Reset (synchronous) restores register defaults, clears the match state and
// the queue, and drops rsp valid; no clearing pass is needed.
`include "whole_word_literal_search_top_assert.svh"

module whole_word_literal_search_top #(
   parameter int unsigned MAX_PATTERN = wwls_pkg::MAX_PATTERN_DEFAULT,
   parameter int unsigned POS_BITS    = wwls_pkg::POS_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   wwls_stream_if.sink                         req_channel,
   wwls_stream_if.source                       rsp_channel,
   input  logic                                csr_write_enable,
   input  logic [wwls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wwls_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   wwls_pkg::cfg_type    cfg;
   wwls_pkg::record_type q_push_data, q_head_data;
   logic                 q_push_valid, q_push_ready;
   logic                 q_head_valid, q_pop;

   wwls_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   wwls_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .POS_BITS    (POS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_channel (req_channel),
      .push_valid  (q_push_valid),
      .push_ready  (q_push_ready),
      .push_data   (q_push_data)
   );

   wwls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_head_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_head_data)
   );

   wwls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_ready  (q_pop),
      .head_data   (q_head_data),
      .rsp_channel (rsp_channel)
   );

   `WWLS_ASSERT_AFTER_RESET(a_no_word_after_reset, clock, reset, !rsp_channel.valid,
      "result word valid right after reset")
   `WWLS_ASSERT_IMPLY(a_pop_has_record, clock, reset, q_pop, q_head_valid,
      "back end took a record from an empty queue")
   `WWLS_ASSERT_IMPLY(a_summary_is_last, clock, reset,
      rsp_channel.valid && (rsp_channel.payload.kind == wwls_pkg::KIND_SUMMARY),
      rsp_channel.payload.last, "summary word not marked last")
   `WWLS_ASSERT_IMPLY(a_match_counted, clock, reset,
      rsp_channel.valid && (rsp_channel.payload.kind == wwls_pkg::KIND_MATCH),
      rsp_channel.payload.match_total != '0, "match word with a zero match total")

endmodule

@@ hw/rtl/wwls_csr.sv @@
// configuration registers of the whole-word literal search block
module wwls_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wwls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wwls_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output wwls_pkg::cfg_type                   cfg
);

   wwls_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (wwls_pkg::csr_index_type'(csr_index))
            wwls_pkg::CSR_PATTERN_LOW:    cfg_in.pattern_low    = csr_write_data;
            wwls_pkg::CSR_PATTERN_HIGH:   cfg_in.pattern_high   = csr_write_data;
            wwls_pkg::CSR_PATTERN_LENGTH: begin
               cfg_in.pattern_length = csr_write_data[wwls_pkg::LEN_BITS-1:0];
            end
            wwls_pkg::CSR_CASE_SENSITIVE: cfg_in.case_sensitive = csr_write_data[0];
            wwls_pkg::CSR_WHOLE_WORD:     cfg_in.whole_word     = csr_write_data[0];
            wwls_pkg::CSR_DELIM_LOW:      cfg_in.delim_low      = csr_write_data;
            wwls_pkg::CSR_DELIM_HIGH:     cfg_in.delim_high     = csr_write_data;
            wwls_pkg::CSR_BEGIN_POSITION: cfg_in.begin_position = csr_write_data[31:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low    <= '0;
         cfg_ff.pattern_high   <= '0;
         cfg_ff.pattern_length <= wwls_pkg::LEN_BITS'(1);
         cfg_ff.case_sensitive <= 1'b1;
         cfg_ff.whole_word     <= 1'b0;
         cfg_ff.delim_low      <= 64'd1;
         cfg_ff.delim_high     <= '0;
         cfg_ff.begin_position <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/wwls_front.sv @@
// front end: shift-and matcher, word boundary checks and per-byte result record
module wwls_front #(
   parameter int unsigned MAX_PATTERN = wwls_pkg::MAX_PATTERN_DEFAULT,
   parameter int unsigned POS_BITS    = wwls_pkg::POS_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wwls_pkg::cfg_type    cfg,
   wwls_stream_if.sink          req_channel,
   output logic                 push_valid,
   input  logic                 push_ready,
   output wwls_pkg::record_type push_data
);

   localparam int unsigned MASK_W = (MAX_PATTERN < wwls_pkg::PATTERN_BYTES) ?
                                    MAX_PATTERN : wwls_pkg::PATTERN_BYTES;
   localparam int unsigned CMP_W  = (POS_BITS > wwls_pkg::OUT_POS_BITS) ?
                                    POS_BITS : wwls_pkg::OUT_POS_BITS;
   localparam int unsigned OW     = wwls_pkg::OUT_POS_BITS;
   localparam int unsigned LW     = wwls_pkg::LEN_BITS;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   function automatic wwls_pkg::rel_type relation(input logic [POS_BITS-1:0] start,
                                                  input logic [31:0]         begin_pos);
      logic [CMP_W-1:0] a;
      logic [CMP_W-1:0] b;
      a = CMP_W'(start);
      b = CMP_W'(begin_pos);
      priority if (a < b)  return wwls_pkg::REL_BEFORE;
      else if (a == b)     return wwls_pkg::REL_EQUAL;
      else                 return wwls_pkg::REL_AFTER;
   endfunction

   logic [MASK_W-1:0]   partial_ff, partial_in;
   logic [MASK_W-1:0]   left_ok_ff, left_ok_in;
   logic [POS_BITS-1:0] position_ff, position_in;
   logic                prev_delim_ff, prev_delim_in;
   logic                pending_ff, pending_in;
   logic [POS_BITS-1:0] pending_start_ff, pending_start_in;
   logic [wwls_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic                overflow_ff, overflow_in;

   logic [7:0]          pat [wwls_pkg::PATTERN_BYTES];
   logic [LW-1:0]       len_eff;
   logic                len_nz;
   logic [wwls_pkg::PAT_IDX_BITS-1:0] last_idx;
   logic                skip_left, skip_right;
   logic [MASK_W-1:0]   len_mask, top_mask, eq, new_partial, new_left;
   logic [7:0]          c;
   logic                eot, cdel, accept, full_hit, left_fine;
   logic                at_max;
   logic [POS_BITS-1:0] end_pos, start_pos, len_pos;
   logic                pend_report, fresh_report, fresh_pending;
   logic [wwls_pkg::TOTAL_BITS-1:0] pend_total, final_total;

   assign c      = req_channel.payload.text_byte;
   assign eot    = req_channel.payload.end_of_text;
   assign accept = req_channel.valid && req_channel.ready;
   assign req_channel.ready = push_ready;

   always_comb begin
      for (int i = 0; i < wwls_pkg::PATTERN_BYTES; i++) begin
         if (i < 8) pat[i] = cfg.pattern_low[8*i +: 8];
         else       pat[i] = cfg.pattern_high[8*(i-8) +: 8];
      end
   end

   assign len_eff  = (cfg.pattern_length > LW'(MASK_W)) ? LW'(MASK_W) : cfg.pattern_length;
   assign len_nz   = (len_eff != '0);
   assign last_idx = wwls_pkg::PAT_IDX_BITS'(len_eff - LW'(1));
   assign skip_left  = len_nz && wwls_pkg::is_delim(pat[0], cfg.delim_low, cfg.delim_high);
   assign skip_right = len_nz &&
                       wwls_pkg::is_delim(pat[last_idx], cfg.delim_low, cfg.delim_high);
   assign cdel = wwls_pkg::is_delim(c, cfg.delim_low, cfg.delim_high);

   always_comb begin
      for (int i = 0; i < MASK_W; i++) begin
         len_mask[i] = (LW'(i) < len_eff);
         eq[i] = cfg.case_sensitive ? (c == pat[i]) :
                 (wwls_pkg::fold(c) == wwls_pkg::fold(pat[i]));
      end
   end

   // one-hot on the last pattern byte, empty for a zero length
   assign top_mask    = len_mask & ~(len_mask >> 1);
   assign new_partial = ((partial_ff << 1) | MASK_W'(1)) & eq & len_mask;
   assign new_left    = ((left_ok_ff << 1) | MASK_W'(skip_left || prev_delim_ff)) & len_mask;
   assign full_hit    = |(new_partial & top_mask);
   assign left_fine   = |(new_left & top_mask);

   assign at_max    = (position_ff == POS_MAX);
   assign end_pos   = at_max ? POS_MAX : position_ff + POS_BITS'(1);
   assign len_pos   = POS_BITS'(len_eff);
   assign start_pos = (end_pos >= len_pos) ? end_pos - len_pos : '0;

   assign pend_report   = pending_ff && (skip_right || cdel);
   assign fresh_report  = full_hit && (!cfg.whole_word || (left_fine && (skip_right || eot)));
   assign fresh_pending = full_hit && cfg.whole_word && left_fine && !skip_right && !eot;

   assign pend_total  = pend_report ? wwls_pkg::sat_inc(total_ff) : total_ff;
   assign final_total = fresh_report ? wwls_pkg::sat_inc(pend_total) : pend_total;

   always_comb begin
      push_data = '0;
      push_data.slots[wwls_pkg::SLOT_PENDING] = pend_report;
      push_data.slots[wwls_pkg::SLOT_FRESH]   = fresh_report;
      push_data.slots[wwls_pkg::SLOT_SUMMARY] = eot;
      push_data.overflow    = overflow_ff || at_max;
      push_data.pend_start  = OW'(pending_start_ff);
      push_data.pend_end    = OW'(end_pos - POS_BITS'(1));
      push_data.pend_rel    = relation(pending_start_ff, cfg.begin_position);
      push_data.pend_total  = pend_total;
      push_data.fresh_start = OW'(start_pos);
      push_data.end_pos     = OW'(end_pos);
      push_data.fresh_rel   = relation(start_pos, cfg.begin_position);
      push_data.final_total = final_total;
   end

   // bytes that cause no result take no queue entry
   assign push_valid = req_channel.valid && (pend_report || fresh_report || eot);

   always_comb begin
      partial_in       = partial_ff;
      left_ok_in       = left_ok_ff;
      position_in      = position_ff;
      prev_delim_in    = prev_delim_ff;
      pending_in       = pending_ff;
      pending_start_in = pending_start_ff;
      total_in         = total_ff;
      overflow_in      = overflow_ff;
      if (accept) begin
         if (eot) begin
            partial_in       = '0;
            left_ok_in       = '0;
            position_in      = '0;
            prev_delim_in    = 1'b1;
            pending_in       = 1'b0;
            pending_start_in = '0;
            total_in         = '0;
            overflow_in      = 1'b0;
         end else begin
            partial_in       = new_partial;
            left_ok_in       = new_left;
            position_in      = end_pos;
            prev_delim_in    = cdel;
            pending_in       = fresh_pending;
            pending_start_in = fresh_pending ? start_pos : pending_start_ff;
            total_in         = final_total;
            overflow_in      = overflow_ff || at_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff       <= '0;
         left_ok_ff       <= '0;
         position_ff      <= '0;
         prev_delim_ff    <= 1'b1;
         pending_ff       <= 1'b0;
         pending_start_ff <= '0;
         total_ff         <= '0;
         overflow_ff      <= 1'b0;
      end else begin
         partial_ff       <= partial_in;
         left_ok_ff       <= left_ok_in;
         position_ff      <= position_in;
         prev_delim_ff    <= prev_delim_in;
         pending_ff       <= pending_in;
         pending_start_ff <= pending_start_in;
         total_ff         <= total_in;
         overflow_ff      <= overflow_in;
      end
   end

endmodule

@@ hw/rtl/wwls_queue.sv @@
// short fifo of result records between the front and back ends
module wwls_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  wwls_pkg::record_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output wwls_pkg::record_type pop_data
);

   localparam int unsigned DEPTH = wwls_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   wwls_pkg::record_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/wwls_back.sv @@
// back end: unpacks each record into result words behind an output register
module wwls_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   output logic                 head_ready,
   input  wwls_pkg::record_type head_data,
   wwls_stream_if.source        rsp_channel
);

   localparam int unsigned SC = wwls_pkg::SLOT_COUNT;

   wwls_pkg::record_type cur_ff, cur_in;
   logic [SC-1:0]        todo_ff, todo_in;
   logic [SC-1:0]        sel, todo_left;
   logic                 out_valid_ff, out_valid_in;
   wwls_pkg::rsp_type    out_ff, out_in;
   logic                 can_load, advance, take_head;

   always_comb begin
      sel = '0;
      priority if (todo_ff[wwls_pkg::SLOT_PENDING]) sel[wwls_pkg::SLOT_PENDING] = 1'b1;
      else if (todo_ff[wwls_pkg::SLOT_FRESH])       sel[wwls_pkg::SLOT_FRESH]   = 1'b1;
      else if (todo_ff[wwls_pkg::SLOT_SUMMARY])     sel[wwls_pkg::SLOT_SUMMARY] = 1'b1;
      else                                          sel = '0;
   end

   assign can_load  = !out_valid_ff || rsp_channel.ready;
   assign advance   = (todo_ff != '0) && can_load;
   assign todo_left = todo_ff & ~sel;
   // refill when idle or as the last word of the current record leaves
   assign take_head = head_valid && ((todo_ff == '0) || (advance && (todo_left == '0)));
   assign head_ready = take_head;

   always_comb begin
      cur_in  = take_head ? head_data : cur_ff;
      todo_in = take_head ? head_data.slots : (advance ? todo_left : todo_ff);
   end

   always_comb begin
      out_in = out_ff;
      if (advance) begin
         out_in.position_overflow = cur_ff.overflow;
         out_in.last              = (todo_left == '0);
         out_in.match_end         = cur_ff.end_pos;
         priority if (sel[wwls_pkg::SLOT_PENDING]) begin
            out_in.kind           = wwls_pkg::KIND_MATCH;
            out_in.match_start    = cur_ff.pend_start;
            out_in.match_end      = cur_ff.pend_end;
            out_in.begin_relation = cur_ff.pend_rel;
            out_in.match_total    = cur_ff.pend_total;
         end else if (sel[wwls_pkg::SLOT_FRESH]) begin
            out_in.kind           = wwls_pkg::KIND_MATCH;
            out_in.match_start    = cur_ff.fresh_start;
            out_in.begin_relation = cur_ff.fresh_rel;
            out_in.match_total    = cur_ff.final_total;
         end else begin
            out_in.kind           = wwls_pkg::KIND_SUMMARY;
            out_in.match_start    = '0;
            out_in.begin_relation = wwls_pkg::REL_BEFORE;
            out_in.match_total    = cur_ff.final_total;
         end
      end
   end

   assign out_valid_in = advance ? 1'b1 : (rsp_channel.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         todo_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         todo_ff      <= todo_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_channel.valid   = out_valid_ff;
   assign rsp_channel.payload = out_ff;

endmodule

@@ sim/tb_whole_word_literal_search_top.sv @@
// self-checking testbench for the whole-word literal search top level
module tb_whole_word_literal_search_top;
   import wwls_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   wwls_stream_if #(.payload_type(req_type)) req_if ();
   wwls_stream_if #(.payload_type(rsp_type)) rsp_if ();

   whole_word_literal_search_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // shadow copy of the register file
   logic [63:0] cfg_pat_low;
   logic [63:0] cfg_pat_high;
   logic [4:0]  cfg_length;
   logic        cfg_case_sensitive;
   logic        cfg_whole_word;
   logic [63:0] cfg_delim_low;
   logic [63:0] cfg_delim_high;
   logic [31:0] cfg_begin;

   // search state of the current text
   logic [15:0] partial_bits;
   logic [15:0] left_ok_bits;
   logic [31:0] text_pos;
   logic        prev_delim;
   logic        held_valid;
   logic [31:0] held_start;
   logic [31:0] match_count;
   logic        pos_overflow;

   rsp_type     expected_words[$];
   rsp_type     step_words[SLOT_COUNT];
   int          step_count;
   logic [7:0]  text_buf[$];

   int fail_count     = 0;
   int words_checked  = 0;
   int bytes_sent     = 0;
   int texts_sent     = 0;
   int configs_used   = 0;
   int send_idle_pct  = 20;
   int stall_pct      = 57;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("whole_word_literal_search_top: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic delimits(input logic [7:0] c);
      if (c == CHAR_NUL || c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
         return 1'b1;
      if (c < 8'd64)
         return cfg_delim_low[c[5:0]];
      if (c < 8'd128)
         return cfg_delim_high[c[5:0]];
      return 1'b0;
   endfunction

   function automatic logic [7:0] lower_letter(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] pattern_char(input int i);
      if (i < 8)
         return cfg_pat_low[8*i +: 8];
      return cfg_pat_high[8*(i-8) +: 8];
   endfunction

   function automatic int active_length();
      return (cfg_length > 5'd16) ? 16 : int'(cfg_length);
   endfunction

   task automatic clear_text_state();
      partial_bits = '0;
      left_ok_bits = '0;
      text_pos     = '0;
      prev_delim   = 1'b1;
      held_valid   = 1'b0;
      held_start   = '0;
      match_count  = '0;
      pos_overflow = 1'b0;
   endtask

   task automatic add_match_word(input logic [31:0] first, input logic [31:0] stop);
      rsp_type w;
      if (match_count != '1)
         match_count++;
      w.kind              = KIND_MATCH;
      w.match_start       = first;
      w.match_end         = stop;
      w.begin_relation    = (first < cfg_begin) ? REL_BEFORE :
                            (first == cfg_begin) ? REL_EQUAL : REL_AFTER;
      w.match_total       = match_count;
      w.position_overflow = pos_overflow;
      w.last              = 1'b0;
      step_words[step_count] = w;
      step_count++;
   endtask

   // works out the result words of one accepted text byte
   task automatic predict_byte(input logic [7:0] c, input logic eot);
      int          len;
      int          i;
      logic [15:0] len_mask;
      logic [15:0] hits;
      logic [15:0] next_partial;
      logic [15:0] next_left;
      logic        skip_left;
      logic        skip_right;
      logic        c_delim;
      logic [31:0] stop;
      logic [31:0] first;
      logic [7:0]  p;
      rsp_type     w;
      len        = active_length();
      len_mask   = 16'((17'd1 << len) - 17'd1);
      skip_left  = 1'b0;
      skip_right = 1'b0;
      if (len != 0) begin
         skip_left  = delimits(pattern_char(0));
         skip_right = delimits(pattern_char(len - 1));
      end
      c_delim    = delimits(c);
      step_count = 0;
      if (text_pos == '1) begin
         pos_overflow = 1'b1;
         stop = text_pos;
      end else begin
         stop = text_pos + 32'd1;
      end
      first = (stop >= 32'(len)) ? stop - 32'(len) : 32'd0;

      // a held match is released only by a delimiting right neighbour
      if (held_valid) begin
         held_valid = 1'b0;
         if (skip_right || c_delim)
            add_match_word(held_start, stop - 32'd1);
      end

      hits = '0;
      for (i = 0; i < len; i++) begin
         p = pattern_char(i);
         if (cfg_case_sensitive ? (c == p) : (lower_letter(c) == lower_letter(p)))
            hits[i] = 1'b1;
      end
      next_partial = {partial_bits[14:0], 1'b1} & hits & len_mask;
      next_left    = {left_ok_bits[14:0], skip_left | prev_delim} & len_mask;

      if (len != 0) begin
         if (next_partial[len-1]) begin
            if (!cfg_whole_word) begin
               add_match_word(first, stop);
            end else if (next_left[len-1]) begin
               if (skip_right || eot) begin
                  add_match_word(first, stop);
               end else begin
                  held_valid = 1'b1;
                  held_start = first;
               end
            end
         end
      end

      partial_bits = next_partial;
      left_ok_bits = next_left;
      prev_delim   = c_delim;
      text_pos     = stop;

      if (eot) begin
         w.kind              = KIND_SUMMARY;
         w.match_start       = '0;
         w.match_end         = stop;
         w.begin_relation    = REL_BEFORE;
         w.match_total       = match_count;
         w.position_overflow = pos_overflow;
         w.last              = 1'b0;
         step_words[step_count] = w;
         step_count++;
         clear_text_state();
      end
      if (step_count > 0)
         step_words[step_count-1].last = 1'b1;
      for (i = 0; i < step_count; i++)
         expected_words.push_back(step_words[i]);
   endtask

   always @(negedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_words.size() == 0) begin
            $error("result word %h arrived with nothing expected", got);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (got.kind !== want.kind) begin
               $error("kind expected %0d got %0d", want.kind, got.kind);
               fail_count++;
            end
            if (got.match_start !== want.match_start) begin
               $error("match_start expected %0d got %0d", want.match_start, got.match_start);
               fail_count++;
            end
            if (got.match_end !== want.match_end) begin
               $error("match_end expected %0d got %0d", want.match_end, got.match_end);
               fail_count++;
            end
            if (got.begin_relation !== want.begin_relation) begin
               $error("begin_relation expected %0d got %0d",
                      want.begin_relation, got.begin_relation);
               fail_count++;
            end
            if (got.match_total !== want.match_total) begin
               $error("match_total expected %0d got %0d", want.match_total, got.match_total);
               fail_count++;
            end
            if (got.position_overflow !== want.position_overflow) begin
               $error("position_overflow expected %0d got %0d",
                      want.position_overflow, got.position_overflow);
               fail_count++;
            end
            if (got.last !== want.last) begin
               $error("last expected %0d got %0d", want.last, got.last);
               fail_count++;
            end
         end
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_PATTERN_LOW:    cfg_pat_low        = data;
         CSR_PATTERN_HIGH:   cfg_pat_high       = data;
         CSR_PATTERN_LENGTH: cfg_length         = data[4:0];
         CSR_CASE_SENSITIVE: cfg_case_sensitive = data[0];
         CSR_WHOLE_WORD:     cfg_whole_word     = data[0];
         CSR_DELIM_LOW:      cfg_delim_low      = data;
         CSR_DELIM_HIGH:     cfg_delim_high     = data;
         CSR_BEGIN_POSITION: cfg_begin          = data[31:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_csrs(input logic [63:0] pat_low, input logic [63:0] pat_high,
                                 input logic [63:0] length, input logic [63:0] exact,
                                 input logic [63:0] word_mode, input logic [63:0] dlow,
                                 input logic [63:0] dhigh, input logic [63:0] begin_pos);
      write_csr(CSR_PATTERN_LOW, pat_low);
      write_csr(CSR_PATTERN_HIGH, pat_high);
      write_csr(CSR_PATTERN_LENGTH, length);
      write_csr(CSR_CASE_SENSITIVE, exact);
      write_csr(CSR_WHOLE_WORD, word_mode);
      write_csr(CSR_DELIM_LOW, dlow);
      write_csr(CSR_DELIM_HIGH, dhigh);
      write_csr(CSR_BEGIN_POSITION, begin_pos);
      configs_used++;
   endtask

   // sender goes quiet until every expected word is back
   task automatic wait_drained(input int settle);
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (expected_words.size() != 0)
         @(negedge clock);
      repeat (settle + 1) @(posedge clock);
   endtask

   task automatic send_text_byte(input logic [7:0] c, input logic eot);
      int      gap;
      req_type w;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 8)
         gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.text_byte   = c;
      w.end_of_text = eot;
      req_if.valid   <= 1'b1;
      req_if.payload <= w;
      @(negedge clock);
      while (!req_if.ready)
         @(negedge clock);
      // taken at the coming edge
      predict_byte(c, eot);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text_buf(input int pause_after);
      int i;
      for (i = 0; i < text_buf.size(); i++) begin
         send_text_byte(text_buf[i], i == text_buf.size() - 1);
         if (i == pause_after)
            wait_drained(0);
      end
      texts_sent++;
      text_buf.delete();
   endtask

   task automatic load_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
   endtask

   function automatic logic [7:0] pick_char();
      case ($urandom_range(11))
         0, 1: return "a";
         2: return "A";
         3: return "b";
         4: return "B";
         5: return CHAR_SPACE;
         6: return ",";
         7: return CHAR_NUL;
         8: return ".";
         9: return CHAR_TAB;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] c);
      logic letter;
      letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      return (letter && $urandom_range(3) == 0) ? c ^ 8'h20 : c;
   endfunction

   task automatic test_reset_values();
      // default pattern is a single NUL, exact compare
      text_buf.push_back("x");
      text_buf.push_back(CHAR_NUL);
      send_text_buf(-1);
      text_buf.push_back(CHAR_NUL);
      send_text_buf(-1);
   endtask

   task automatic test_overlap_fold();
      wait_drained(4);
      write_all_csrs(64'h4161, '1, 64'd2, 64'd0, 64'd0, 64'd0, 64'd0, 64'd1);
      // overlapping folded matches, start before, at and after begin
      load_text("AaAa");
      send_text_buf(-1);
   endtask

   task automatic test_three_words();
      wait_drained(4);
      // 'A' delimits, so the first pattern byte skips the left check
      write_all_csrs(64'h6141, 64'd0, 64'd2, 64'd0, 64'd1, 64'd1, 64'd2, 64'd1);
      load_text("AaA");
      send_text_buf(-1);
   endtask

   task automatic test_word_boundaries();
      wait_drained(4);
      write_all_csrs(64'h746163, 64'd0, 64'd3, 64'd1, 64'd1,
                     (64'd1 << 44) | 64'd1, 64'd0, 64'hFFFF_FFFF);
      // held match released by the comma, later one dropped by the s
      load_text("cat,cats");
      send_text_buf(2);
   endtask

   task automatic test_length_zero();
      wait_drained(4);
      write_csr(CSR_PATTERN_LENGTH, 64'd0);
      load_text("c");
      send_text_buf(-1);
   endtask

   task automatic random_config();
      logic [127:0] pat;
      logic [63:0]  junk;
      logic [63:0]  dlow;
      logic [63:0]  dhigh;
      logic [31:0]  begin_pos;
      logic [4:0]   len;
      int           i;
      int           r;
      for (i = 0; i < 16; i++)
         pat[8*i +: 8] = pick_char();
      r = $urandom_range(19);
      case (r)
         0: len = 5'd0;
         1: len = 5'd16;
         2: len = 5'($urandom_range(31, 17));
         3: len = 5'd1;
         default: len = 5'($urandom_range(5, 2));
      endcase
      if (r == 1 && $urandom_range(1) == 1)
         pat = '1;
      junk = {$urandom, $urandom};
      case ($urandom_range(3))
         0: dlow = '0;
         1: dlow = '1;
         2: dlow = (64'd1 << 44) | (64'd1 << 46);
         default: dlow = {$urandom, $urandom};
      endcase
      case ($urandom_range(3))
         0: dhigh = '0;
         1: dhigh = '1;
         2: dhigh = 64'd2;
         default: dhigh = {$urandom, $urandom};
      endcase
      case ($urandom_range(3))
         0: begin_pos = '0;
         1: begin_pos = '1;
         default: begin_pos = 32'($urandom_range(12));
      endcase
      write_all_csrs(pat[63:0], pat[127:64], {junk[63:5], len},
                     {junk[63:1], 1'($urandom_range(1))},
                     {junk[63:1], 1'($urandom_range(3) != 0)},
                     dlow, dhigh, {junk[63:32], begin_pos});
   endtask

   // mostly pattern copies and near misses, with delimiters and noise between
   task automatic random_text();
      int len;
      int pieces;
      int n;
      int i;
      len    = active_length();
      pieces = $urandom_range(6, 1);
      repeat (pieces) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               for (i = 0; i < len; i++)
                  text_buf.push_back(vary_case(pattern_char(i)));
            end
            4: begin
               if (len > 1) begin
                  n = $urandom_range(len - 1, 1);
                  for (i = 0; i < n; i++)
                     text_buf.push_back(vary_case(pattern_char(i)));
               end
            end
            5: begin
               case ($urandom_range(2))
                  0: text_buf.push_back(CHAR_SPACE);
                  1: text_buf.push_back(",");
                  default: text_buf.push_back(CHAR_NUL);
               endcase
            end
            6, 7: text_buf.push_back(pick_char());
            default: text_buf.push_back(8'($urandom_range(255)));
         endcase
      end
      if (text_buf.size() == 0)
         text_buf.push_back(pick_char());
   endtask

   task automatic test_random_stream(input int count, input int send_pct, input int stall);
      int stop_at;
      int pause_at;
      send_idle_pct = send_pct;
      stall_pct     = stall;
      stop_at       = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         wait_drained(4);
         random_config();
         repeat ($urandom_range(5, 2)) begin
            if (bytes_sent < stop_at) begin
               random_text();
               pause_at = ($urandom_range(9) == 0) ? $urandom_range(text_buf.size() - 1) : -1;
               send_text_buf(pause_at);
            end
         end
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.payload   <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_PATTERN_LOW;
      csr_write_data   <= '0;
      cfg_pat_low        = '0;
      cfg_pat_high       = '0;
      cfg_length         = 5'd1;
      cfg_case_sensitive = 1'b1;
      cfg_whole_word     = 1'b0;
      cfg_delim_low      = 64'd1;
      cfg_delim_high     = '0;
      cfg_begin          = '0;
      clear_text_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_overlap_fold();
      test_three_words();
      test_word_boundaries();
      test_length_zero();
      test_random_stream(86, 20, 57);
      test_random_stream(86, 57, 20);
      test_random_stream(86, 0, 0);

      wait_drained(10);
      $display("covered %0d texts, %0d bytes and %0d result words over %0d register settings",
               texts_sent, bytes_sent, words_checked, configs_used);
      $display("settings spanned pattern lengths 0 to 31, exact and folded compare, "
               , "whole-word on and off");
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("whole_word_literal_search_top: match");
      end else begin
         $display("whole_word_literal_search_top: mismatch");
      end
      $finish;
   end

endmodule
